[rtl/core/skt_pkg.sv]
// Shared types, constants and helpers for the sorted key table.
// No dependencies.
package skt_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = 4;
  localparam int OCNT_W    = 5;
  localparam int HEAD_W    = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  typedef logic [KEY_WIDTH-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic do_ins;
    logic do_rem;
    key_t key;
  } cell_ctrl_t;

  // Compare flags that each cell reports.
  typedef struct packed {
    logic ins_mark; // entry unused or stored key above request key
    logic ge;       // entry used and stored key at or above request key
    logic eq;       // entry used and stored key equal to request key
  } cell_flags_t;

  function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] mask);
    logic [IDX_W-1:0] idx;
    logic             found;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (mask[i] && !found) begin
        idx   = IDX_W'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

[rtl/core/skt_cell.sv]
// One slot of the sorted key table: holds a key, compares it with the request
// and shifts toward either neighbor. Depends on skt_pkg.
module skt_cell
  import skt_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  cell_ctrl_t  ctrl,
  input  logic        valid,
  input  logic        left_ins_mark,
  input  key_t        left_key,
  input  key_t        right_key,
  output key_t        key_q,
  output key_t        key_nxt,
  output cell_flags_t flags
);

  key_t key_r;

  assign key_q          = key_r;
  assign flags.ins_mark = !valid || (key_r > ctrl.key);
  assign flags.ge       = valid && (key_r >= ctrl.key);
  assign flags.eq       = valid && (key_r == ctrl.key);

  always_comb begin
    key_nxt = key_r;
    if (ctrl.do_ins) begin
      if (left_ins_mark) begin
        key_nxt = left_key;
      end else if (flags.ins_mark) begin
        key_nxt = ctrl.key;
      end
    end else if (ctrl.do_rem && flags.ge) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_r <= key_nxt;
    end
  end

endmodule

[rtl/core/sorted_key_table_unit.sv]
// Sorted key table top level: a row of compare-and-shift cells, entry count
// and registered result. Depends on skt_pkg and skt_cell.
//
// Use: each input request carries a command on in_tuser (insert, remove,
// find) and a key on in_tdata. Insert places the key after equal keys,
// remove deletes the lowest-position equal key, find reports its position.
// Every request gives exactly one result with status, position, entry count
// and the key at the head of the table.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the result side takes every
// result; all cells compare and shift in the same cycle.
// A request is taken whenever the result register is empty or is being
// emptied in the same cycle; while the receiver stalls, the result holds and
// in_tready stays low.
// Reset empties the table (entry count zero) and drops any pending result;
// key storage itself is not cleared.
module sorted_key_table_unit
  import skt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] key
  input  logic [1:0]            in_tuser,   // [1:0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [1:0] status, [5:2] position,
                                            // [10:6] entry_count,
                                            // [42:11] smallest_key, rest zero
);

  logic                 in_fire;
  cmd_t                 cmd;
  cell_ctrl_t           ctrl;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  key_t                 keys    [CAPACITY];
  key_t                 keys_nx [CAPACITY];
  cell_flags_t          flags   [CAPACITY];
  logic [CAPACITY-1:0]  valid_v, ins_v, ge_v, eq_v;
  logic                 full, hit;
  logic [IDX_W-1:0]     ins_idx, ge_idx;
  status_t              status;
  logic [IDX_W-1:0]     pos;
  logic [HEAD_W-1:0]    head;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);

  assign full    = (count_r >= CNT_W'(CAPACITY));
  assign ins_idx = first_set(ins_v);
  assign ge_idx  = first_set(ge_v);
  assign hit     = |ge_v && eq_v[ge_idx];

  assign ctrl.key    = in_tdata[KEY_WIDTH-1:0];
  assign ctrl.do_ins = in_fire && (cmd == CMD_INSERT) && !full;
  assign ctrl.do_rem = in_fire && (cmd == CMD_REMOVE) && hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid_v[i] = (CNT_W'(i) < count_r);
    assign ins_v[i]   = flags[i].ins_mark;
    assign ge_v[i]    = flags[i].ge;
    assign eq_v[i]    = flags[i].eq;

    skt_cell u_cell (
      .clk           (clk),
      .en            (in_fire),
      .ctrl          (ctrl),
      .valid         (valid_v[i]),
      .left_ins_mark (i == 0 ? 1'b0 : ins_v[(i == 0) ? 0 : i - 1]),
      .left_key      (keys[(i == 0) ? 0 : i - 1]),
      .right_key     (keys[(i == CAPACITY - 1) ? i : i + 1]),
      .key_q         (keys[i]),
      .key_nxt       (keys_nx[i]),
      .flags         (flags[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.do_rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    status = ST_MISSING;
    pos    = '0;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          status = ST_OK;
          pos    = ins_idx;
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        if (hit) begin
          status = ST_OK;
          pos    = ge_idx;
        end
      end
      default: begin
        status = ST_MISSING;
      end
    endcase
  end

  assign head = (count_nxt != '0) ? HEAD_W'(keys_nx[0]) : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[1:0]   = status;
      out_data_nxt[5:2]   = POS_W'(pos);
      out_data_nxt[10:6]  = OCNT_W'(count_nxt);
      out_data_nxt[42:11] = head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == CMD_INSERT && !full) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the table");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[1:0] == ST_FULL) |->
      (out_data_r[5:2] == '0 && out_data_r[10:6] == OCNT_W'(CAPACITY)))
    else $error("full result with wrong position or count");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("request stalled with empty result register");
`endif

endmodule

[tb/tb_sorted_key_table_unit.sv]
// Self-checking bench for sorted_key_table_unit: stream requests with random idling
// on both sides, predict each result from a local sorted table, compare per field.
// Depends on skt_pkg and the sorted_key_table_unit RTL.
module tb_sorted_key_table_unit;
  import skt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [OCNT_W-1:0]  entry_count;
    logic [HEAD_W-1:0]  smallest_key;
  } table_result_t;

  typedef struct {
    cmd_t op;
    key_t key;
  } table_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  table_req_t    pending_reqs[$];
  table_result_t expected_results[$];
  key_t          sent_keys[$];
  key_t          key_pool[8];

  key_t          table_keys[CAPACITY];
  int            table_count = 0;

  int            src_idle_pct = 0;
  int            sink_stall_pct = 0;
  int            fail_count = 0;
  int            checked_count = 0;
  int            full_count = 0;
  int            miss_count = 0;
  int            peak_count = 0;
  int            cycle_count = 0;
  table_result_t want;
  table_req_t    next_req;

  sorted_key_table_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic table_result_t apply_table_op(input cmd_t op, input key_t k);
    table_result_t r;
    int            slot;
    int            hit;
    r.status   = ST_MISSING;
    r.position = '0;
    hit = -1;
    for (int i = 0; i < table_count; i++)
      if (hit < 0 && table_keys[i] == k) hit = i;
    case (op)
      CMD_INSERT: begin
        if (table_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          slot = table_count;
          for (int i = table_count - 1; i >= 0; i--)
            if (table_keys[i] > k) slot = i;
          for (int i = table_count; i > slot; i--)
            table_keys[i] = table_keys[i-1];
          table_keys[slot] = k;
          table_count++;
          r.status   = ST_OK;
          r.position = POS_W'(slot);
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < table_count; i++)
            table_keys[i] = table_keys[i+1];
          table_count--;
          r.status   = ST_OK;
          r.position = POS_W'(hit);
        end
      end
      CMD_FIND: begin
        if (hit >= 0) begin
          r.status   = ST_OK;
          r.position = POS_W'(hit);
        end
      end
      default: ;
    endcase
    r.entry_count  = OCNT_W'(table_count);
    r.smallest_key = (table_count > 0) ? HEAD_W'(table_keys[0]) : '0;
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_table_op(cmd_t'(in_tuser), in_tdata));
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_req.key;
          in_tuser  <= next_req.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: out_tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (want.status == ST_FULL) full_count++;
        if (want.status == ST_MISSING) miss_count++;
        if (int'(want.entry_count) > peak_count) peak_count = want.entry_count;
        if (out_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[5:2] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_tdata[5:2]);
          fail_count++;
        end
        if (out_tdata[10:6] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_tdata[10:6]);
          fail_count++;
        end
        if (out_tdata[42:11] !== want.smallest_key) begin
          $error("smallest_key: expected %h, got %h", want.smallest_key, out_tdata[42:11]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("sorted_key_table_unit: mismatch");
      $finish;
    end
  end

  task automatic push_req(input cmd_t op, input key_t k);
    table_req_t r;
    r.op  = op;
    r.key = k;
    pending_reqs.push_back(r);
    if (op == CMD_INSERT) begin
      sent_keys.push_back(k);
      if (sent_keys.size() > 32) void'(sent_keys.pop_front());
    end
  endtask

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 50 && sent_keys.size() > 0) return sent_keys[$urandom_range(sent_keys.size() - 1)];
    if (r < 80) return key_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  // bursts of varying insert weight fill, drain and churn the table
  task automatic queue_random(input int n);
    int ins_w;
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) ins_w = $urandom_range(20, 80);
      r = $urandom_range(99);
      if (r < ins_w) push_req(CMD_INSERT, pick_key());
      else if (r >= 98) push_req(CMD_NONE, $urandom());
      else if (r % 2 == 0) push_req(CMD_REMOVE, pick_key());
      else push_req(CMD_FIND, pick_key());
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    queue_random(n);
    wait_drained();
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    push_req(CMD_FIND, 32'h0000_0005);
    push_req(CMD_REMOVE, 32'h0000_0005);
    push_req(CMD_NONE, '1);
    push_req(CMD_INSERT, '1);
    push_req(CMD_INSERT, '0);
    push_req(CMD_INSERT, 32'h0000_0005);
    push_req(CMD_INSERT, 32'h0000_0005);
    push_req(CMD_INSERT, 32'h0000_0005);
    push_req(CMD_FIND, 32'h0000_0005);
    push_req(CMD_REMOVE, 32'h0000_0005);
    push_req(CMD_FIND, '1);
    push_req(CMD_NONE, 32'h0000_0005);
    for (int i = 0; i < 12; i++) push_req(CMD_INSERT, $urandom());
    push_req(CMD_INSERT, 32'h0000_0003);
    push_req(CMD_FIND, '0);
    wait_drained();

    run_phase(0, 0, 300);
    run_phase(78, 0, 300);
    run_phase(0, 78, 300);
    run_phase(21, 21, 300);

    repeat (10) @(posedge clk);
    $display("checked %0d results over four idling phases: %0d full rejects, %0d misses",
             checked_count, full_count, miss_count);
    $display("peak table occupancy %0d of %0d, %0d field errors", peak_count, CAPACITY,
             fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("sorted_key_table_unit: match");
    end else begin
      $display("sorted_key_table_unit: mismatch");
    end
    $finish;
  end

endmodule
